>>> hw/rtl/calm_pkg.sv
`timescale 1ns / 1ps

package calm_pkg;

    localparam logic             OP_ADD         = 1'b0;
    localparam logic             OP_CHECK       = 1'b1;
    localparam logic [1:0]       FAM_IPV4       = 2'd0;
    localparam logic [1:0]       FAM_IPV6       = 2'd1;
    localparam logic signed [8:0] PREFIX_DEFAULT = -9'sd1;
    localparam logic [7:0]       IPV4_BITS      = 8'd32;
    localparam logic [7:0]       IPV6_BITS      = 8'd128;

    typedef struct packed {
        logic [8:0]  prefix;
        logic [63:0] addr_lo;
        logic [63:0] addr_hi;
        logic [1:0]  family;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // Entry hit test: same family (IPv4 or IPv6), prefix in range or -1 for the full width, top prefix bits equal.
    function automatic logic entry_match(entry_t e, logic [1:0] fam,
                                         logic [63:0] hi, logic [63:0] lo);
        logic signed [8:0] p;
        logic [7:0]        n;
        logic [31:0]       m4;
        logic [127:0]      m6;
        logic              hit;
        begin
            p   = $signed(e.prefix);
            n   = 8'd0;
            hit = 1'b0;
            m4  = '0;
            m6  = '0;
            if (e.family == fam && fam == FAM_IPV4) begin
                if (p == PREFIX_DEFAULT) begin
                    n = IPV4_BITS;
                end else if (p >= 9'sd1 && p <= 9'sd32) begin
                    n = p[7:0];
                end
                m4  = ~(32'hFFFF_FFFF >> n);
                hit = (n != 8'd0) && (((lo[31:0] ^ e.addr_lo[31:0]) & m4) == 32'd0);
            end else if (e.family == fam && fam == FAM_IPV6) begin
                if (p == PREFIX_DEFAULT) begin
                    n = IPV6_BITS;
                end else if (p >= 9'sd1 && p <= 9'sd128) begin
                    n = p[7:0];
                end
                m6  = ~({128{1'b1}} >> n);
                hit = (n != 8'd0) &&
                      ((({hi, lo} ^ {e.addr_hi, e.addr_lo}) & m6) == 128'd0);
            end
            return hit;
        end
    endfunction

endpackage

>>> hw/rtl/calm_table.sv
`timescale 1ns / 1ps

module calm_table #(
    parameter int  TABLE_DEPTH = 16,
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  calm_pkg::entry_t wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output calm_pkg::entry_t rd_data
);
    import calm_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/cidr_access_list_match.sv
`timescale 1ns / 1ps

// CIDR access list: an ordered table of allowed prefixes in one synchronous RAM.
// Input channel s_*: s_tuser selects the operation (0 add entry, 1 check client).
// An add appends family, address and prefix length at the fill count; when the
// table holds TABLE_DEPTH entries the add is refused with status 1.
// A check reads the stored entries in order, one RAM read per cycle, and
// answers allow 1 on the first matching entry, or at once if the table is empty.
// Result channel m_*: one transfer per input transfer, allow in bit 0 and
// status in bit 1 of m_tdata.
// Flow: an add goes from ST_ADD to ST_RESULT. A check stays in ST_SCAN while it
// reads entries, up to the first hit plus one more or the whole fill count, and
// compares each entry as its RAM read returns, then passes to ST_RESULT.
// One item is in work at a time; s_tready is high while the block is idle.
// A result held by a stalled receiver stays in the output register; the next
// item is taken meanwhile and its result waits until the register frees.
// Reset (aresetn low) empties the table at once; no clearing pass is needed.
module cidr_access_list_match #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // family[1:0], addr_hi[65:2], addr_lo[129:66],
                                   // prefix_len[138:130], zero fill
    input  logic [0:0]   s_tuser,  // op[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata   // allow[0], status[1], zero fill
);
    import calm_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    state_t           state_reg, state_next;
    entry_t           item_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             pend_reg, pend_next;
    logic             hit_reg, hit_next;
    logic             res_allow_reg, res_allow_next;
    logic             res_status_reg, res_status_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [1:0]       m_bits_reg, m_bits_next;

    logic             s_fire;
    logic             wr_en;
    logic             rd_en;
    entry_t           rd_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_bits_reg};

    calm_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(count_reg[IDX_W-1:0]),
        .wr_data(item_reg),
        .rd_addr(scan_reg[IDX_W-1:0]),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.family  <= s_tdata[1:0];
            item_reg.addr_hi <= s_tdata[65:2];
            item_reg.addr_lo <= s_tdata[129:66];
            item_reg.prefix  <= s_tdata[138:130];
        end
        res_allow_reg  <= res_allow_next;
        res_status_reg <= res_status_next;
        m_bits_reg     <= m_bits_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        pend_next       = 1'b0;
        hit_next        = hit_reg;
        res_allow_next  = res_allow_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_bits_next     = m_bits_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    state_next = (s_tuser[0] == OP_ADD) ? ST_ADD : ST_SCAN;
                end
            end
            ST_ADD: begin
                res_allow_next = 1'b0;
                if (count_reg == FULL_COUNT) begin
                    res_status_next = 1'b1;
                end else begin
                    res_status_next = 1'b0;
                    wr_en           = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                end
                state_next = ST_RESULT;
            end
            ST_SCAN: begin
                // read issued here returns next cycle; compare on returned entry
                if (pend_reg && entry_match(rd_data, item_reg.family,
                                            item_reg.addr_hi, item_reg.addr_lo)) begin
                    hit_next = 1'b1;
                end
                rd_en = (scan_reg != count_reg) && !hit_reg;
                if (rd_en) begin
                    scan_next = scan_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (!rd_en && !pend_reg) begin
                    res_allow_next  = hit_reg || (count_reg == '0);
                    res_status_next = 1'b0;
                    state_next      = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_bits_next   = {res_status_reg, res_allow_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> tb/sv/access_list_monitor.sv
`timescale 1ns / 1ps

module access_list_monitor #(
    parameter int DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,  // family[1:0], addr_hi[65:2], addr_lo[129:66],
                                   // prefix_len[138:130], zero fill
    input  logic [0:0]   s_tuser,  // op[0]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,  // allow[0], status[1], zero fill
    output int           mismatches,
    output int           pending
);
    import calm_pkg::*;

    typedef struct {
        logic allow;
        logic status;
    } verdict_t;

    verdict_t           verdicts[$];
    logic [1:0]         acl_fam[DEPTH];
    logic [127:0]       acl_addr[DEPTH];
    logic signed [8:0]  acl_plen[DEPTH];
    int unsigned        acl_fill;

    // address bits are compared from the first (most significant) bit down
    function automatic logic prefix_hit(int k, logic [1:0] fam, logic [127:0] addr);
        int width;
        int n;
        if (acl_fam[k] != fam) return 1'b0;
        if (fam == FAM_IPV4) width = 32;
        else if (fam == FAM_IPV6) width = 128;
        else return 1'b0;
        n = int'(acl_plen[k]);
        if (n == -1) n = width;
        if (n < 1 || n > width) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (addr[width-1-i] !== acl_addr[k][width-1-i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic verdict_t apply_item(logic op, logic [1:0] fam, logic [127:0] addr,
                                            logic signed [8:0] plen);
        verdict_t v;
        v.allow  = 1'b0;
        v.status = 1'b0;
        if (op == OP_ADD) begin
            if (acl_fill >= DEPTH) begin
                v.status = 1'b1;
            end else begin
                acl_fam[acl_fill]  = fam;
                acl_addr[acl_fill] = addr;
                acl_plen[acl_fill] = plen;
                acl_fill++;
            end
        end else if (acl_fill == 0) begin
            v.allow = 1'b1;
        end else begin
            for (int k = 0; k < acl_fill; k++) begin
                if (prefix_hit(k, fam, addr)) v.allow = 1'b1;
            end
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            acl_fill = 0;
            verdicts.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                verdicts.push_back(apply_item(s_tuser[0], s_tdata[1:0],
                                              {s_tdata[65:2], s_tdata[129:66]},
                                              $signed(s_tdata[138:130])));
            end
            if (m_tvalid && m_tready) begin
                if (verdicts.size() == 0) begin
                    $display("%0t: unexpected result transfer, allow %0b status %0b",
                             $time, m_tdata[0], m_tdata[1]);
                    mismatches++;
                end else begin
                    want = verdicts.pop_front();
                    if (m_tdata[0] !== want.allow) begin
                        $display("%0t: allow expected %0b actual %0b",
                                 $time, want.allow, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[1] !== want.status) begin
                        $display("%0t: status expected %0b actual %0b",
                                 $time, want.status, m_tdata[1]);
                        mismatches++;
                    end
                end
            end
        end
        pending = verdicts.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import calm_pkg::*;

    localparam int DEPTH = 16;
    localparam int ITEMS = 900;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    int           mismatches;
    int           pending;
    bit           quiet = 1'b0;
    int           stall_left = 0;
    int           rx_roll;

    // entries handed to the block, used to aim checks near stored prefixes
    logic [1:0]   added_fam[DEPTH];
    logic [127:0] added_addr[DEPTH];
    int           added_len[DEPTH];
    int           added = 0;

    always #5 aclk = ~aclk;

    cidr_access_list_match #(.TABLE_DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    access_list_monitor #(.DEPTH(DEPTH)) monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(negedge aclk) begin
        if (!aresetn || quiet) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 60) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                stall_left <= (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic op, input logic [1:0] fam, input logic [63:0] hi,
                             input logic [63:0] lo, input logic [8:0] plen);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, plen, lo, hi, fam};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (op == OP_ADD && added < DEPTH) begin
            added_fam[added]  = fam;
            added_addr[added] = {hi, lo};
            added_len[added]  = int'($signed(plen));
            added++;
        end
    endtask

    task automatic add_random();
        logic [1:0]   f;
        logic [127:0] a;
        logic [8:0]   p;
        int           width;
        int           r;
        r = $urandom_range(0, 99);
        f = (r < 45) ? FAM_IPV4 : (r < 85) ? FAM_IPV6 : 2'($urandom_range(2, 3));
        width = (f == FAM_IPV4) ? 32 : 128;
        a = {$urandom, $urandom, $urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 20) p = 9'h1FF;
        else if (r < 60) p = 9'($urandom_range(1, width));
        else if (r < 70) p = 9'(width);
        else if (r < 75) p = 9'd0;
        else if (r < 80) p = 9'(width + 1);
        else p = 9'($urandom_range(0, 511));
        send_item(OP_ADD, f, a[127:64], a[63:0], p);
    endtask

    task automatic check_near(input int k);
        logic [1:0]   f;
        logic [127:0] a;
        int           width;
        int           n;
        int           r;
        f = added_fam[k];
        a = added_addr[k];
        width = (f == FAM_IPV4) ? 32 : 128;
        n = (added_len[k] == -1) ? width : added_len[k];
        if (n < 0) n = 0;
        if (n > width) n = width;
        if (f == FAM_IPV4) a[127:32] = {$urandom, $urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 40) begin
            for (int i = 0; i < width - n; i++) a[i] = 1'($urandom_range(0, 1));
        end else if (r < 70 && n > 0) begin
            a[width-1-$urandom_range(0, n-1)] ^= 1'b1;
        end
        if ($urandom_range(0, 9) == 0) f = 2'($urandom_range(0, 3));
        send_item(OP_CHECK, f, a[127:64], a[63:0], 9'($urandom_range(0, 511)));
    endtask

    task automatic check_random();
        send_item(OP_CHECK, 2'($urandom_range(0, 3)), {$urandom, $urandom},
                  {$urandom, $urandom}, 9'($urandom_range(0, 511)));
    endtask

    initial begin
        int r;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table allows anything
        send_item(OP_CHECK, FAM_IPV4, 64'h0, 64'h0A00_0001, 9'd0);
        send_item(OP_CHECK, 2'd3, '1, '1, 9'h1FF);
        send_item(OP_ADD, FAM_IPV4, 64'h0, 64'h0A00_0000, 9'd8);
        send_item(OP_CHECK, FAM_IPV4, '1, 64'hFFFF_FFFF_0AFF_1234, 9'd0);
        send_item(OP_CHECK, FAM_IPV4, 64'h0, 64'h0B00_0000, 9'd0);
        send_item(OP_CHECK, FAM_IPV6, '1, '1, 9'd0);
        send_item(OP_ADD, FAM_IPV4, 64'h0, 64'h0, 9'd0);
        send_item(OP_ADD, FAM_IPV4, 64'h0, 64'hC0A8_0101, 9'd33);
        send_item(OP_ADD, FAM_IPV4, 64'hDEAD_BEEF_0000_0001, 64'h1234_5678_C0A8_0101, 9'h1FF);
        send_item(OP_ADD, FAM_IPV6, '1, '1, 9'd128);
        send_item(OP_ADD, FAM_IPV6, 64'h2001_0DB8_0000_0000, 64'h1, 9'h1FF);
        send_item(OP_ADD, FAM_IPV6, 64'h0, 64'h0, 9'd129);
        send_item(OP_ADD, 2'd2, 64'h0, 64'h0, 9'd8);
        send_item(OP_ADD, 2'd3, '1, '1, 9'h1FF);
        send_item(OP_ADD, FAM_IPV6, 64'h0, 64'h0, 9'd1);
        send_item(OP_ADD, FAM_IPV6, 64'h0123_4567_89AB_CDEF, 64'h8000_0000_0000_0000, 9'd65);
        send_item(OP_ADD, FAM_IPV4, 64'h0, 64'h0, 9'h100);
        send_item(OP_ADD, FAM_IPV4, 64'h0, 64'hFFFF_FFFF, 9'd32);
        send_item(OP_CHECK, FAM_IPV4, 64'h0, 64'h0000_0000_C0A8_0101, 9'd0);
        send_item(OP_CHECK, FAM_IPV4, 64'h0, 64'h0000_0000_C0A8_0100, 9'd0);
        send_item(OP_CHECK, FAM_IPV6, '1, 64'hFFFF_FFFF_FFFF_FFFE, 9'd0);
        send_item(OP_CHECK, FAM_IPV6, '1, '1, 9'd0);
        send_item(OP_CHECK, 2'd2, 64'h0, 64'h0, 9'd8);
        send_item(OP_CHECK, 2'd3, '1, '1, 9'h1FF);
        send_item(OP_CHECK, FAM_IPV6, 64'h0123_4567_89AB_CDEF, 64'h8FFF_0000_1234_0000, 9'd0);

        for (int i = 0; i < ITEMS; i++) begin
            quiet <= (i >= 300 && i < 380);
            if (i == 500) begin
                // drain the block completely before going on
                s_tvalid <= 1'b0;
                while (pending != 0) @(negedge aclk);
                repeat (30) @(negedge aclk);
            end
            r = $urandom_range(0, 99);
            if (r < 12) add_random();
            else if (r < 75 && added > 0) check_near($urandom_range(0, added - 1));
            else check_random();
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
